// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every clock edge
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcd_pkg
// Types, codes and helpers of the ISO-on-TCP receive deframer
// ----------------------------------------------------------------------------
package tcd_pkg;

  // parameter walk limit per connect confirm
  localparam logic [3:0] MAX_PARAMS = 4'd8;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_FRAME   = 2'd0;
  localparam logic [1:0] CFG_MAX_MESSAGE = 2'd1;
  localparam logic [1:0] CFG_SIZE_CODE   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_CONNECT   = 2'd1;
  localparam logic [1:0] KIND_MALFORMED = 2'd2;
  localparam logic [1:0] KIND_EMPTY_END = 2'd3;

  // fault causes
  localparam logic [2:0] CAUSE_NONE      = 3'd0;
  localparam logic [2:0] CAUSE_VERSION   = 3'd1;
  localparam logic [2:0] CAUSE_LENGTH    = 3'd2;
  localparam logic [2:0] CAUSE_INDICATOR = 3'd3;
  localparam logic [2:0] CAUSE_HEADER    = 3'd4;
  localparam logic [2:0] CAUSE_PARAM     = 3'd5;
  localparam logic [2:0] CAUSE_OVERFLOW  = 3'd6;

  // protocol byte values
  localparam logic [7:0] TPKT_VERSION = 8'h03;
  localparam logic [7:0] TPDU_CC      = 8'hD0;
  localparam logic [7:0] TPDU_DT      = 8'hF0;
  localparam logic [7:0] PARAM_SIZE   = 8'hC0;

  // size code bounds
  localparam logic [3:0] SIZE_CODE_MIN   = 4'd7;
  localparam logic [3:0] SIZE_CODE_MAX   = 4'd13;
  localparam logic [3:0] SIZE_CODE_RESET = 4'd10;

  typedef enum logic [3:0] {
    PH_HEAD,
    PH_LI,
    PH_CODE,
    PH_DT_FLAG,
    PH_DT_BODY,
    PH_CC_BODY,
    PH_CC_LEN,
    PH_SKIP,
    PH_FAULT
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        message_end;
    logic [2:0]  error_cause;
    logic [13:0] tpdu_size_bytes;
    logic [31:0] frames_received;
    logic [31:0] malformed_count;
  } result_t;

  // clamp a size code into 7..13
  function automatic logic [3:0] clamp_code(input logic [7:0] c);
    logic [3:0] r;
    if (c < {4'd0, SIZE_CODE_MIN}) begin
      r = SIZE_CODE_MIN;
    end else if (c > {4'd0, SIZE_CODE_MAX}) begin
      r = SIZE_CODE_MAX;
    end else begin
      r = c[3:0];
    end
    return r;
  endfunction

endpackage

// ----- design/tcd_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcd_in_if
// Receive byte stream channel: valid/ready with byte and restart flag
// ----------------------------------------------------------------------------
interface tcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       restart;

  modport source (output valid, output rx_byte, output restart, input ready);
  modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

// ----- design/tcd_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcd_out_if
// Deframer result channel: valid/ready with event fields and counters
// ----------------------------------------------------------------------------
interface tcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        message_end;
  logic [2:0]  error_cause;
  logic [13:0] tpdu_size_bytes;
  logic [31:0] frames_received;
  logic [31:0] malformed_count;

  modport source (output valid, output kind, output data_byte, output message_end,
                  output error_cause, output tpdu_size_bytes, output frames_received,
                  output malformed_count, input ready);
  modport sink   (input valid, input kind, input data_byte, input message_end,
                  input error_cause, input tpdu_size_bytes, input frames_received,
                  input malformed_count, output ready);
endinterface

// ----- design/tpkt_cotp_stream_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpkt_cotp_stream_deframer
// ISO-on-TCP receive deframer: TPKT framing, COTP connect confirm and data
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock while results drain, and gives at
// most one result per byte. A byte passes an input register, the parser stage
// and a result register. The sustained rate is one byte every cycle, set by
// the parser stage, which updates all frame state for each byte. Backpressure
// on the result channel stalls input only while both registers are full. There
// is no memory and no clearing pass after reset. Configuration writes belong
// to idle periods.
module tpkt_cotp_stream_deframer
  import tcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  tcd_in_if.sink      in_ch,
  tcd_out_if.source   out_ch
);

  logic     q_valid;
  in_item_t q_item;
  logic     out_free;
  logic     adv;
  logic     res_valid;
  result_t  res;

  // parser advances when a byte is held and the result register has room
  assign adv = q_valid && out_free;

  // input stage
  tcd_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .pop     (adv),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  // parser stage
  tcd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .adv       (adv),
    .item      (q_item),
    .res_valid (res_valid),
    .res       (res)
  );

  // result stage
  tcd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .out_ch    (out_ch)
  );

endmodule

// ----- design/tcd_in_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcd_in_reg
// Input register stage: holds one received transaction for the parser
// ----------------------------------------------------------------------------
module tcd_in_reg
  import tcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  tcd_in_if.sink   in_ch,
  input  logic     pop,
  output logic     q_valid,
  output in_item_t q_item
);

  logic     q_valid_r, q_valid_nxt;
  in_item_t q_item_r;
  logic     take;

  // room when empty or when the held transaction leaves this cycle
  assign in_ch.ready = !q_valid_r || pop;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    if (take) begin
      q_valid_nxt = 1'b1;
    end else begin
      q_valid_nxt = q_valid_r && !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= q_valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (take) begin
      q_item_r <= '{rx_byte: in_ch.rx_byte, restart: in_ch.restart};
    end
  end

  assign q_valid = q_valid_r;
  assign q_item  = q_item_r;

endmodule

// ----- design/tcd_parser.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// tcd_parser
// Per-byte frame parser: header checks, TPDU dispatch, parameter walk,
// message assembly, fault latch, counters and configuration registers
// ----------------------------------------------------------------------------
module tcd_parser
  import tcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        adv,
  input  in_item_t    item,
  output logic        res_valid,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] byte_position_r, byte_position_nxt;
  logic [15:0] frame_length_r, frame_length_nxt;
  logic [8:0]  tpdu_end_r, tpdu_end_nxt;
  logic [15:0] param_next_r, param_next_nxt;
  logic [7:0]  param_code_r, param_code_nxt;
  logic [7:0]  param_length_r, param_length_nxt;
  logic [3:0]  param_count_r, param_count_nxt;
  logic        end_flag_r, end_flag_nxt;
  logic [15:0] assembled_count_r, assembled_count_nxt;
  logic [3:0]  size_code_r, size_code_nxt;
  logic        error_latched_r, error_latched_nxt;
  logic [31:0] received_counter_r, received_counter_nxt;
  logic [31:0] malformed_counter_r, malformed_counter_nxt;
  logic [15:0] max_frame_bytes_r, max_frame_bytes_nxt;
  logic [15:0] max_message_bytes_r, max_message_bytes_nxt;

  logic [7:0]  b;
  logic [15:0] o;
  logic        last;
  logic        fail;
  logic [2:0]  fail_cause;
  logic        emit;
  logic [1:0]  e_kind;
  logic [7:0]  e_data;
  logic        e_mend;
  logic        eflag;
  logic        closing;
  logic [15:0] user_len;
  logic [16:0] msg_total;
  logic [16:0] param_stop;

  assign b         = item.rx_byte;
  assign o         = byte_position_r - 16'd4;
  assign last      = ({1'b0, byte_position_r} + 17'd1) == {1'b0, frame_length_r};
  assign user_len  = frame_length_r - 16'd4 - {7'd0, tpdu_end_r};
  assign msg_total = {1'b0, assembled_count_r} + {1'b0, user_len};
  assign param_stop = {1'b0, param_next_r} + 17'd2 + {9'd0, b};

  // next state and result
  always_comb begin
    phase_nxt             = phase_r;
    byte_position_nxt     = byte_position_r;
    frame_length_nxt      = frame_length_r;
    tpdu_end_nxt          = tpdu_end_r;
    param_next_nxt        = param_next_r;
    param_code_nxt        = param_code_r;
    param_length_nxt      = param_length_r;
    param_count_nxt       = param_count_r;
    end_flag_nxt          = end_flag_r;
    assembled_count_nxt   = assembled_count_r;
    size_code_nxt         = size_code_r;
    error_latched_nxt     = error_latched_r;
    received_counter_nxt  = received_counter_r;
    malformed_counter_nxt = malformed_counter_r;
    max_frame_bytes_nxt   = max_frame_bytes_r;
    max_message_bytes_nxt = max_message_bytes_r;
    fail       = 1'b0;
    fail_cause = CAUSE_NONE;
    emit       = 1'b0;
    e_kind     = KIND_PAYLOAD;
    e_data     = 8'd0;
    e_mend     = 1'b0;
    eflag      = end_flag_r;
    closing    = 1'b0;

    if (cfg_we) begin
      // register writes
      unique case (cfg_index)
        CFG_MAX_FRAME:   max_frame_bytes_nxt = cfg_wdata;
        CFG_MAX_MESSAGE: max_message_bytes_nxt = cfg_wdata;
        CFG_SIZE_CODE:   size_code_nxt = clamp_code({4'd0, cfg_wdata[3:0]});
        default: ;
      endcase
    end else if (adv) begin
      if (item.restart) begin
        // abandon frame and message
        phase_nxt           = PH_HEAD;
        byte_position_nxt   = 16'd0;
        error_latched_nxt   = 1'b0;
        assembled_count_nxt = 16'd0;
        end_flag_nxt        = 1'b0;
      end else if (error_latched_r || phase_r == PH_FAULT) begin
        // latched fault: swallow bytes
      end else if (phase_r == PH_HEAD) begin
        // four-byte packet header
        if (byte_position_r[1:0] == 2'd0 && b != TPKT_VERSION) begin
          fail = 1'b1;
          fail_cause = CAUSE_VERSION;
        end else if (byte_position_r[1:0] == 2'd1 && b != 8'd0) begin
          fail = 1'b1;
          fail_cause = CAUSE_VERSION;
        end else begin
          if (byte_position_r[1:0] == 2'd2) begin
            frame_length_nxt = {b, 8'h00};
          end
          if (byte_position_r[1:0] == 2'd3) begin
            frame_length_nxt = {frame_length_r[15:8], b};
            if ({frame_length_r[15:8], b} < 16'd7 ||
                {frame_length_r[15:8], b} > max_frame_bytes_r) begin
              fail = 1'b1;
              fail_cause = CAUSE_LENGTH;
            end else begin
              phase_nxt = PH_LI;
            end
          end
          if (!fail) begin
            byte_position_nxt = byte_position_r + 16'd1;
          end
        end
      end else begin
        unique case (phase_r)
          PH_LI: begin
            if (b < 8'd2 || ({8'd0, b} + 16'd1) > (frame_length_r - 16'd4)) begin
              fail = 1'b1;
              fail_cause = CAUSE_INDICATOR;
            end else begin
              tpdu_end_nxt         = {1'b0, b} + 9'd1;
              received_counter_nxt = received_counter_r + 32'd1;
              phase_nxt            = PH_CODE;
            end
          end
          PH_CODE: begin
            if (b == TPDU_CC) begin
              if (tpdu_end_r < 9'd7) begin
                fail = 1'b1;
                fail_cause = CAUSE_HEADER;
              end else begin
                param_next_nxt   = 16'd7;
                param_code_nxt   = 8'd0;
                param_length_nxt = 8'd0;
                param_count_nxt  = 4'd0;
                phase_nxt        = PH_CC_BODY;
              end
            end else if (b == TPDU_DT) begin
              if (msg_total > {1'b0, max_message_bytes_r}) begin
                fail = 1'b1;
                fail_cause = CAUSE_OVERFLOW;
              end else begin
                phase_nxt = PH_DT_FLAG;
              end
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_DT_FLAG, PH_DT_BODY: begin
            if (phase_r == PH_DT_FLAG) begin
              eflag = b[7];
            end
            end_flag_nxt = eflag;
            phase_nxt    = PH_DT_BODY;
            closing      = last && eflag;
            if (o >= {7'd0, tpdu_end_r}) begin
              assembled_count_nxt = closing ? 16'd0 : assembled_count_r + 16'd1;
              emit   = 1'b1;
              e_kind = KIND_PAYLOAD;
              e_data = b;
              e_mend = closing;
            end else if (closing) begin
              assembled_count_nxt = 16'd0;
              emit   = 1'b1;
              e_kind = KIND_EMPTY_END;
              e_mend = 1'b1;
            end
          end
          PH_CC_BODY: begin
            // size value lands on the byte after its length
            if (param_code_r == PARAM_SIZE && param_length_r == 8'd1 &&
                ({1'b0, o} + 17'd1) == {1'b0, param_next_r}) begin
              size_code_nxt = clamp_code(b);
            end
            if (o == param_next_r && param_count_r < MAX_PARAMS &&
                ({1'b0, param_next_r} + 17'd2) <= {8'd0, tpdu_end_r}) begin
              param_code_nxt = b;
              phase_nxt      = PH_CC_LEN;
            end
            if (last) begin
              emit   = 1'b1;
              e_kind = KIND_CONNECT;
            end
          end
          PH_CC_LEN: begin
            if (param_stop > {8'd0, tpdu_end_r}) begin
              fail = 1'b1;
              fail_cause = CAUSE_PARAM;
            end else begin
              param_length_nxt = b;
              param_next_nxt   = param_stop[15:0];
              param_count_nxt  = param_count_r + 4'd1;
              phase_nxt        = PH_CC_BODY;
              if (last) begin
                emit   = 1'b1;
                e_kind = KIND_CONNECT;
              end
            end
          end
          default: ;
        endcase
        // frame position
        if (!fail) begin
          if (last) begin
            phase_nxt         = PH_HEAD;
            byte_position_nxt = 16'd0;
          end else begin
            byte_position_nxt = byte_position_r + 16'd1;
          end
        end
      end

      // fault latch
      if (fail) begin
        malformed_counter_nxt = malformed_counter_r + 32'd1;
        error_latched_nxt     = 1'b1;
        phase_nxt             = PH_FAULT;
        emit   = 1'b1;
        e_kind = KIND_MALFORMED;
        e_data = 8'd0;
        e_mend = 1'b0;
      end
    end

    res_valid           = adv && emit;
    res.kind            = e_kind;
    res.data_byte       = e_data;
    res.message_end     = e_mend;
    res.error_cause     = fail_cause;
    res.tpdu_size_bytes = 14'd1 << size_code_nxt;
    res.frames_received = received_counter_nxt;
    res.malformed_count = malformed_counter_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r             <= PH_HEAD;
      byte_position_r     <= 16'd0;
      frame_length_r      <= 16'd0;
      tpdu_end_r          <= 9'd0;
      param_next_r        <= 16'd0;
      param_code_r        <= 8'd0;
      param_length_r      <= 8'd0;
      param_count_r       <= 4'd0;
      end_flag_r          <= 1'b0;
      assembled_count_r   <= 16'd0;
      size_code_r         <= SIZE_CODE_RESET;
      error_latched_r     <= 1'b0;
      received_counter_r  <= 32'd0;
      malformed_counter_r <= 32'd0;
      max_frame_bytes_r   <= 16'hFFFF;
      max_message_bytes_r <= 16'hFFFF;
    end else begin
      phase_r             <= phase_nxt;
      byte_position_r     <= byte_position_nxt;
      frame_length_r      <= frame_length_nxt;
      tpdu_end_r          <= tpdu_end_nxt;
      param_next_r        <= param_next_nxt;
      param_code_r        <= param_code_nxt;
      param_length_r      <= param_length_nxt;
      param_count_r       <= param_count_nxt;
      end_flag_r          <= end_flag_nxt;
      assembled_count_r   <= assembled_count_nxt;
      size_code_r         <= size_code_nxt;
      error_latched_r     <= error_latched_nxt;
      received_counter_r  <= received_counter_nxt;
      malformed_counter_r <= malformed_counter_nxt;
      max_frame_bytes_r   <= max_frame_bytes_nxt;
      max_message_bytes_r <= max_message_bytes_nxt;
    end
  end

  // checks
  `ASSERT_SAME(a_latch_phase, error_latched_r, phase_r == PH_FAULT, "error latched outside fault phase")
  `ASSERT_SAME(a_head_pos, phase_r == PH_HEAD, byte_position_r < 16'd4, "header phase past byte four")
  `ASSERT_ALWAYS(a_size_range, size_code_r >= SIZE_CODE_MIN && size_code_r <= SIZE_CODE_MAX, "size code out of range")
  `ASSERT_NEXT(a_mal_count, res_valid && res.kind == KIND_MALFORMED, malformed_counter_r == $past(malformed_counter_r) + 32'd1, "malformed result without count step")

endmodule

// ----- design/tcd_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcd_out_reg
// Result register: holds one result transaction until the sink takes it
// ----------------------------------------------------------------------------
module tcd_out_reg
  import tcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  logic      res_valid,
  input  result_t   res,
  output logic      free,
  tcd_out_if.source out_ch
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // register can take a new result when empty or being drained
  assign free = !valid_r || out_ch.ready;

  always_comb begin
    if (load) begin
      valid_nxt = res_valid;
    end else begin
      valid_nxt = valid_r && !out_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.kind            = res_r.kind;
  assign out_ch.data_byte       = res_r.data_byte;
  assign out_ch.message_end     = res_r.message_end;
  assign out_ch.error_cause     = res_r.error_cause;
  assign out_ch.tpdu_size_bytes = res_r.tpdu_size_bytes;
  assign out_ch.frames_received = res_r.frames_received;
  assign out_ch.malformed_count = res_r.malformed_count;

endmodule

// ----- test/tb_tpkt_cotp_stream_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tpkt_cotp_stream_deframer
// Self-checking bench for the ISO-on-TCP receive deframer. Directed frames
// cover header, indicator, connect confirm, data, skip and overflow cases.
// Random streams of good, broken and cut-off frames then run under several
// register settings. Input gaps and output stalls are random throughout.
// ----------------------------------------------------------------------------
module tb_tpkt_cotp_stream_deframer;
  import tcd_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 4;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  tcd_in_if  in_ch ();
  tcd_out_if out_ch ();

  tpkt_cotp_stream_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // deframer state as predicted
  phase_t      st_phase;
  logic [15:0] st_pos;
  logic [15:0] st_frame_len;
  logic [8:0]  st_tpdu_end;
  logic [15:0] st_param_next;
  logic [7:0]  st_param_code;
  logic [7:0]  st_param_len;
  logic [3:0]  st_param_cnt;
  logic        st_end_flag;
  logic [15:0] st_assembled;
  logic [3:0]  st_size_code;
  logic        st_latched;
  logic [31:0] st_frames;
  logic [31:0] st_faults;
  logic [15:0] max_frame;
  logic [15:0] max_message;

  // expected results in order, and bench bookkeeping
  result_t    results_due[$];
  logic [7:0] frame_buf[$];
  logic [7:0] param_buf[$];
  int         live_items   = 0;
  int         restarts     = 0;
  int         results_seen = 0;
  int         faults_seen  = 0;
  int         mismatches   = 0;
  int         cycle_count  = 0;
  int         stall_left   = 0;
  bit         in_gap_on    = 1'b1;
  bit         out_stall_on = 1'b1;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic logic [3:0] limit_size(input logic [7:0] v);
    logic [3:0] c;
    c = v[3:0];
    if (v < {4'h0, SIZE_CODE_MIN}) c = SIZE_CODE_MIN;
    if (v > {4'h0, SIZE_CODE_MAX}) c = SIZE_CODE_MAX;
    return c;
  endfunction

  function automatic result_t make_result(input logic [1:0] k, input logic [7:0] d,
                                          input logic me, input logic [2:0] cause);
    result_t r;
    r.kind            = k;
    r.data_byte       = d;
    r.message_end     = me;
    r.error_cause     = cause;
    r.tpdu_size_bytes = 14'd1 << st_size_code;
    r.frames_received = st_frames;
    r.malformed_count = st_faults;
    return r;
  endfunction

  // count the fault and latch until restart
  function automatic result_t refuse_frame(input logic [2:0] cause);
    st_faults  = st_faults + 1;
    st_latched = 1'b1;
    st_phase   = PH_FAULT;
    return make_result(KIND_MALFORMED, 8'h00, 1'b0, cause);
  endfunction

  // advance the parser by one accepted byte; returns 1 when a result is due
  function automatic bit predict_byte(input logic [7:0] b, input logic rs,
                                      output result_t r);
    int unsigned tpdu_off;
    bit          last;
    bit          hit;
    r   = '0;
    hit = 1'b0;
    if (rs) begin
      st_phase     = PH_HEAD;
      st_pos       = '0;
      st_latched   = 1'b0;
      st_assembled = '0;
      st_end_flag  = 1'b0;
      return 1'b0;
    end
    if (st_latched || st_phase == PH_FAULT) return 1'b0;

    // four-byte packet header
    if (st_phase == PH_HEAD) begin
      if ((st_pos == 0 && b != TPKT_VERSION) || (st_pos == 1 && b != 8'h00)) begin
        r = refuse_frame(CAUSE_VERSION);
        return 1'b1;
      end
      if (st_pos == 2) st_frame_len = {b, 8'h00};
      if (st_pos == 3) begin
        st_frame_len[7:0] = b;
        if (st_frame_len < 7 || st_frame_len > max_frame) begin
          r = refuse_frame(CAUSE_LENGTH);
          return 1'b1;
        end
        st_phase = PH_LI;
      end
      st_pos = st_pos + 1;
      return 1'b0;
    end

    tpdu_off = st_pos - 4;
    last     = (st_pos + 1 == st_frame_len);
    case (st_phase)
      PH_LI: begin
        if (b < 2 || b + 1 > st_frame_len - 4) begin
          r = refuse_frame(CAUSE_INDICATOR);
          return 1'b1;
        end
        st_tpdu_end = {1'b0, b} + 9'd1;
        st_frames   = st_frames + 1;
        st_phase    = PH_CODE;
      end
      PH_CODE: begin
        if (b == TPDU_CC) begin
          if (st_tpdu_end < 7) begin
            r = refuse_frame(CAUSE_HEADER);
            return 1'b1;
          end
          st_param_next = 16'd7;
          st_param_code = 8'h00;
          st_param_len  = 8'h00;
          st_param_cnt  = 4'd0;
          st_phase      = PH_CC_BODY;
        end else if (b == TPDU_DT) begin
          if (st_assembled + ((st_frame_len - 4) - st_tpdu_end) > max_message) begin
            r = refuse_frame(CAUSE_OVERFLOW);
            return 1'b1;
          end
          st_phase = PH_DT_FLAG;
        end else begin
          st_phase = PH_SKIP;
        end
      end
      PH_DT_FLAG, PH_DT_BODY: begin
        if (st_phase == PH_DT_FLAG) begin
          st_end_flag = b[7];
          st_phase    = PH_DT_BODY;
        end
        if (tpdu_off >= st_tpdu_end) begin
          if (last && st_end_flag) begin
            st_assembled = '0;
            r = make_result(KIND_PAYLOAD, b, 1'b1, CAUSE_NONE);
          end else begin
            st_assembled = st_assembled + 1;
            r = make_result(KIND_PAYLOAD, b, 1'b0, CAUSE_NONE);
          end
          hit = 1'b1;
        end else if (last && st_end_flag) begin
          st_assembled = '0;
          r   = make_result(KIND_EMPTY_END, 8'h00, 1'b1, CAUSE_NONE);
          hit = 1'b1;
        end
      end
      PH_CC_BODY: begin
        // size value lands on the byte after its length
        if (st_param_code == PARAM_SIZE && st_param_len == 8'd1 &&
            tpdu_off + 1 == st_param_next)
          st_size_code = limit_size(b);
        if (tpdu_off == st_param_next && st_param_cnt < MAX_PARAMS &&
            st_param_next + 2 <= st_tpdu_end) begin
          st_param_code = b;
          st_phase      = PH_CC_LEN;
        end
        if (last) begin
          r   = make_result(KIND_CONNECT, 8'h00, 1'b0, CAUSE_NONE);
          hit = 1'b1;
        end
      end
      PH_CC_LEN: begin
        if (st_param_next + 2 + b > st_tpdu_end) begin
          r = refuse_frame(CAUSE_PARAM);
          return 1'b1;
        end
        st_param_len  = b;
        st_param_next = st_param_next + 2 + b;
        st_param_cnt  = st_param_cnt + 1;
        st_phase      = PH_CC_BODY;
        if (last) begin
          r   = make_result(KIND_CONNECT, 8'h00, 1'b0, CAUSE_NONE);
          hit = 1'b1;
        end
      end
      default: ;
    endcase

    if (last) begin
      st_phase = PH_HEAD;
      st_pos   = '0;
    end else begin
      st_pos = st_pos + 1;
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (!in_gap_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // one input transaction, predicted once accepted
  task automatic send_item(input logic [7:0] b, input logic rs);
    int      gap;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.restart <= rs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!rs && !st_latched) live_items++;
    if (predict_byte(b, rs, r)) results_due.push_back(r);
  endtask

  task automatic send_restart();
    restarts++;
    send_item($urandom_range(0, 255), 1'b1);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_item(frame_buf[i], 1'b0);
    frame_buf.delete();
  endtask

  // drop valid and wait until every expected result is out
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all three registers on consecutive edges, block idle
  task automatic write_config(input logic [15:0] frame_cap, input logic [15:0] msg_cap,
                              input logic [3:0] code);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_FRAME;
    cfg_wdata <= frame_cap;
    @(posedge clk);
    cfg_index <= CFG_MAX_MESSAGE;
    cfg_wdata <= msg_cap;
    @(posedge clk);
    cfg_index <= CFG_SIZE_CODE;
    cfg_wdata <= {12'h000, code};
    @(posedge clk);
    cfg_we       <= 1'b0;
    max_frame    = frame_cap;
    max_message  = msg_cap;
    st_size_code = limit_size({4'h0, code});
  endtask

  // ---------------------------------------------------------------------------
  // frame building
  // ---------------------------------------------------------------------------

  task automatic push_random(input int n);
    repeat (n) frame_buf.push_back($urandom_range(0, 255));
  endtask

  task automatic push_tpkt(input int total);
    frame_buf.push_back(TPKT_VERSION);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(total[15:8]);
    frame_buf.push_back(total[7:0]);
  endtask

  // data TPDU: LI, code, flag byte, extra header bytes, user data
  task automatic build_dt(input int user_len, input bit eot, input int extra);
    logic [7:0] li;
    logic [7:0] flag;
    li      = 2 + extra;
    flag    = $urandom_range(0, 255);
    flag[7] = eot;
    push_tpkt(7 + extra + user_len);
    frame_buf.push_back(li);
    frame_buf.push_back(TPDU_DT);
    frame_buf.push_back(flag);
    push_random(extra + user_len);
  endtask

  task automatic push_param(input logic [7:0] code, input int len);
    logic [7:0] len_byte;
    len_byte = len;
    param_buf.push_back(code);
    param_buf.push_back(len_byte);
    repeat (len) param_buf.push_back($urandom_range(0, 255));
  endtask

  task automatic push_size(input logic [7:0] v);
    param_buf.push_back(PARAM_SIZE);
    param_buf.push_back(8'd1);
    param_buf.push_back(v);
  endtask

  // connect confirm around whatever sits in param_buf
  task automatic build_cc(input int tail);
    logic [7:0] li;
    li = 6 + param_buf.size();
    push_tpkt(5 + li + tail);
    frame_buf.push_back(li);
    frame_buf.push_back(TPDU_CC);
    push_random(5);
    foreach (param_buf[i]) frame_buf.push_back(param_buf[i]);
    param_buf.delete();
    push_random(tail);
  endtask

  task automatic build_other(input logic [7:0] code, input int li, input int tail);
    logic [7:0] li_byte;
    li_byte = li;
    push_tpkt(5 + li + tail);
    frame_buf.push_back(li_byte);
    frame_buf.push_back(code);
    push_random(li - 1 + tail);
  endtask

  function automatic int pick_user_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 8);
    if (roll < 96) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_header_checks();
    // wrong version byte, then nonzero reserved byte
    frame_buf.push_back(8'h04);
    send_frame();
    send_restart();
    frame_buf.push_back(TPKT_VERSION);
    frame_buf.push_back(8'h01);
    send_frame();
    send_restart();
    // total length below the minimum
    push_tpkt(6);
    send_frame();
    send_restart();
    push_tpkt(0);
    send_frame();
    send_restart();
    // indicator too small, and running past the TPDU
    push_tpkt(7);
    frame_buf.push_back(8'h00);
    send_frame();
    send_restart();
    push_tpkt(8);
    frame_buf.push_back(8'h04);
    send_frame();
    send_restart();
    // largest indicator
    build_dt(3, 1'b1, 253);
    send_frame();
  endtask

  task automatic test_connect_confirm();
    push_size(8'h0B);
    build_cc(0);
    send_frame();
    // size clamps at both ends
    push_size(8'h00);
    push_param(8'h85, 2);
    build_cc(2);
    send_frame();
    push_size(8'hFF);
    build_cc(0);
    send_frame();
    // walk stops before a ninth parameter
    repeat (8) push_param(8'h85, 0);
    push_size(8'h09);
    build_cc(0);
    send_frame();
    // size code with the wrong length is not taken
    push_param(PARAM_SIZE, 2);
    build_cc(3);
    send_frame();
    // header too short for a connect confirm
    build_other(TPDU_CC, 5, 0);
    send_frame();
    send_restart();
    // parameter value running past the header
    push_param(8'h85, 1);
    param_buf.push_back(PARAM_SIZE);
    param_buf.push_back(8'h03);
    build_cc(0);
    send_frame();
    send_restart();
  endtask

  task automatic test_data_transfer();
    build_dt(3, 1'b1, 0);
    send_frame();
    // message split over two frames, the second one empty
    build_dt(2, 1'b0, 1);
    send_frame();
    build_dt(0, 1'b1, 0);
    send_frame();
    build_dt(0, 1'b0, 0);
    send_frame();
    build_dt(1, 1'b1, 3);
    send_frame();
    // other TPDU codes are passed over
    build_other(8'hE0, 6, 4);
    send_frame();
    build_other(8'h00, 2, 0);
    send_frame();
  endtask

  task automatic test_message_cap();
    settle();
    write_config(16'hFFFF, 16'd5, 4'd10);
    build_dt(3, 1'b0, 0);
    send_frame();
    build_dt(3, 1'b1, 0);
    send_frame();
    send_restart();
    build_dt(5, 1'b1, 0);
    send_frame();
    // restart drops a partial message
    build_dt(4, 1'b0, 0);
    send_frame();
    send_restart();
    build_dt(5, 1'b1, 0);
    send_frame();
    build_dt(6, 1'b1, 0);
    send_frame();
    send_restart();
  endtask

  task automatic test_restart_mid_frame();
    build_dt(6, 1'b1, 0);
    for (int i = 0; i < 8; i++) send_item(frame_buf[i], 1'b0);
    frame_buf.delete();
    send_restart();
    build_dt(2, 1'b1, 0);
    send_frame();
  endtask

  task automatic test_register_minimums();
    settle();
    write_config(16'd7, 16'd1, SIZE_CODE_MAX);
    push_tpkt(16'hFFFF);
    send_frame();
    send_restart();
    push_tpkt(8);
    send_frame();
    send_restart();
    build_dt(0, 1'b1, 0);
    send_frame();
    build_dt(0, 1'b0, 0);
    send_frame();
  endtask

  // one random frame: mostly well formed, some broken or cut off
  task automatic random_frame();
    int pick;
    int n;
    in_gap_on    = ($urandom_range(0, 3) != 0);
    out_stall_on = ($urandom_range(0, 3) != 0);
    if (st_latched && $urandom_range(0, 9) != 0) send_restart();
    // with a tiny frame cap only minimal frames get through
    if (max_frame < 16 && $urandom_range(0, 1) == 1) begin
      build_dt(0, $urandom_range(0, 1), 0);
      send_frame();
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      n = ($urandom_range(0, 99) == 0) ? $urandom_range(5, 253) : $urandom_range(0, 4);
      build_dt(pick_user_len(), $urandom_range(0, 1), n);
      send_frame();
    end else if (pick < 65) begin
      n = $urandom_range(0, 10);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: push_size($urandom_range(5, 15));
          1: push_size($urandom_range(0, 255));
          2: push_param($urandom_range(0, 255), $urandom_range(0, 4));
          default: push_param(PARAM_SIZE, $urandom_range(0, 3));
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        param_buf.push_back($urandom_range(0, 255));
        param_buf.push_back($urandom_range(1, 30));
      end
      build_cc($urandom_range(0, 4));
      send_frame();
    end else if (pick < 73) begin
      build_other($urandom_range(0, 255), $urandom_range(2, 12), $urandom_range(0, 6));
      send_frame();
    end else if (pick < 88) begin
      // corrupt header, length or indicator, or drop the last byte
      build_dt($urandom_range(0, 8), $urandom_range(0, 1), $urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0: frame_buf[$urandom_range(0, 5)] = $urandom_range(0, 255);
        1: frame_buf[3] = $urandom_range(0, 8);
        2: frame_buf[4] = $urandom_range(0, 255);
        default: void'(frame_buf.pop_back());
      endcase
      send_frame();
      if ($urandom_range(0, 4) != 0) send_restart();
    end else if (pick < 95) begin
      build_dt(pick_user_len(), 1'b1, 0);
      n = $urandom_range(1, frame_buf.size() - 1);
      for (int i = 0; i < n; i++) send_item(frame_buf[i], 1'b0);
      frame_buf.delete();
      send_restart();
    end else begin
      push_random($urandom_range(1, 10));
      send_frame();
      send_restart();
    end
  endtask

  task automatic run_random(input int target);
    int start;
    start = live_items;
    while (live_items - start < target) random_frame();
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  // result ready with random stalls, mostly short
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   = stall_left - 1;
    end else if (out_stall_on && $urandom_range(0, 99) < 20) begin
      out_ch.ready <= 1'b0;
      stall_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, kind %0d data %0d", $time, out_ch.kind,
                 out_ch.data_byte);
      end else begin
        want = results_due.pop_front();
        if (want.kind == KIND_MALFORMED) faults_seen++;
        check_field("kind", want.kind, out_ch.kind);
        check_field("data_byte", want.data_byte, out_ch.data_byte);
        check_field("message_end", want.message_end, out_ch.message_end);
        check_field("error_cause", want.error_cause, out_ch.error_cause);
        check_field("tpdu_size_bytes", want.tpdu_size_bytes, out_ch.tpdu_size_bytes);
        check_field("frames_received", want.frames_received, out_ch.frames_received);
        check_field("malformed_count", want.malformed_count, out_ch.malformed_count);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               results_due.size());
      $display("tb_tpkt_cotp_stream_deframer: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MAX_FRAME;
    cfg_wdata     = 16'h0000;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    in_ch.restart = 1'b0;
    out_ch.ready  = 1'b0;

    // state after reset
    st_phase      = PH_HEAD;
    st_pos        = '0;
    st_frame_len  = '0;
    st_tpdu_end   = '0;
    st_param_next = '0;
    st_param_code = '0;
    st_param_len  = '0;
    st_param_cnt  = '0;
    st_end_flag   = 1'b0;
    st_assembled  = '0;
    st_size_code  = SIZE_CODE_RESET;
    st_latched    = 1'b0;
    st_frames     = '0;
    st_faults     = '0;
    max_frame     = 16'hFFFF;
    max_message   = 16'hFFFF;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_checks();
    test_connect_confirm();
    test_data_transfer();
    test_restart_mid_frame();
    test_message_cap();
    test_register_minimums();
    run_random(60);

    settle();
    write_config(16'hFFFF, 16'hFFFF, SIZE_CODE_MIN);
    run_random(250);

    settle();
    write_config($urandom_range(24, 300), $urandom_range(4, 80), $urandom_range(8, 12));
    run_random(250);

    settle();
    write_config(16'hFFFF, 16'hFFFF, SIZE_CODE_RESET);
    run_random(220);

    settle();
    $display("stream of %0d parsed bytes and %0d restarts gave %0d results, %0d of them faults",
             live_items, restarts, results_seen, faults_seen);
    $display("random frames under four register settings, %0d cycles, %0d mismatches",
             cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("tb_tpkt_cotp_stream_deframer: PASS");
    end else begin
      $display("tb_tpkt_cotp_stream_deframer: FAIL");
    end
    $finish;
  end

endmodule
